/* rtl/load_store_unit_macros.svh */
// Assertion macros used by the checker in rtl/lsu_checker.sv.
`ifndef LOAD_STORE_UNIT_MACROS_SVH
`define LOAD_STORE_UNIT_MACROS_SVH

`define LSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define LSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/lsu_pkg.sv */
`default_nettype none
package lsu_pkg;
	localparam int SLOTS = 4;
	localparam int ROB_DEPTH = 16;
	localparam int MEM_WORDS = 1024;
	localparam int MAX_LATENCY = 8;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int TAG_W = $clog2(ROB_DEPTH);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int PIPE_W = $clog2(MAX_LATENCY);
	localparam logic [3:0] LATENCY_RESET = 4'd2;

	typedef enum logic [2:0] {
		CMD_ISSUE = 3'd0,
		CMD_BROADCAST = 3'd1,
		CMD_CYCLE = 3'd2,
		CMD_MEM_WRITE = 3'd3,
		CMD_RETIRE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIPE,
		ST_SCAN,
		ST_MEM,
		ST_DISP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic store;
		logic [31:0] vj;
		logic [31:0] vk;
		logic [31:0] imm;
		logic [31:0] seq;
		logic [4:0] qj;
		logic [4:0] qk;
		logic [3:0] dest;
	} slot_t;

	typedef struct packed {
		logic store;
		logic [31:0] val1;
		logic [31:0] val2;
		logic [31:0] imm;
		logic [3:0] tag;
		logic [3:0] cycles;
		logic [SLOT_W-1:0] slot;
	} pipe_t;

	typedef struct packed {
		logic [3:0] done_tag;
		logic bad_address;
		logic was_store;
		logic [31:0] load_value;
		logic [9:0] store_address_out;
		logic [31:0] store_value_out;
		logic was_forwarded;
	} result_t;
endpackage
`default_nettype wire

/* rtl/lsu_if.sv */
`default_nettype none
interface lsu_in_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [1:0] rs_slot;
	logic is_store;
	logic signed [31:0] base_value;
	logic signed [4:0] base_wait_tag;
	logic signed [31:0] store_data;
	logic signed [4:0] store_wait_tag;
	logic signed [31:0] offset;
	logic [3:0] dest_tag;
	logic [31:0] order_number;
	logic [3:0] window_head;
	logic [4:0] window_count;
	modport source (output valid, command, rs_slot, is_store, base_value, base_wait_tag,
		store_data, store_wait_tag, offset, dest_tag, order_number, window_head,
		window_count, input ready);
	modport sink (input valid, command, rs_slot, is_store, base_value, base_wait_tag,
		store_data, store_wait_tag, offset, dest_tag, order_number, window_head,
		window_count, output ready);
endinterface

interface lsu_out_if;
	logic valid;
	logic ready;
	logic [3:0] done_tag;
	logic bad_address;
	logic was_store;
	logic signed [31:0] load_value;
	logic [9:0] store_address_out;
	logic signed [31:0] store_value_out;
	logic was_forwarded;
	modport source (output valid, done_tag, bad_address, was_store, load_value,
		store_address_out, store_value_out, was_forwarded, input ready);
	modport sink (input valid, done_tag, bad_address, was_store, load_value,
		store_address_out, store_value_out, was_forwarded, output ready);
endinterface
`default_nettype wire

/* rtl/load_store_unit.sv */
// Channel  Direction  Contents
// req      in         command with slot, operands, tags and reorder window
// rsp      out        completion of one access: tag, fault, load or store data
// cfg      in         write of the pipeline latency
//
// Issue, broadcast, memory write and retire are done in the idle state and leave req ready.
// A cycle command keeps req not ready while it walks the pipeline entries, scans the
// reorder window and reads memory for each completing load, then dispatches and ends.
// After reset the data memory is cleared word by word while req is not ready.
// A result waiting on rsp is held; the next command is still taken meanwhile.
// A cycle command with a new result waits in its last state until rsp can take it.
`default_nettype none
module load_store_unit
	import lsu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	lsu_in_if.sink req,
	lsu_out_if.source rsp,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata
);
	state_t state_q, state_d;
	logic [3:0] lat_q;
	logic [MEM_AW-1:0] clr_q;
	logic [SLOTS-1:0] busy_q, exec_q;
	slot_t slot_q [SLOTS];
	pipe_t pipe_q [MAX_LATENCY];
	logic [PIPE_W:0] plen_q, pi_q, keep_q;
	logic [ROB_DEPTH-1:0] rv_q;
	logic [9:0] raddr_q [ROB_DEPTH];
	logic [31:0] rval_q [ROB_DEPTH];
	logic [TAG_W-1:0] head_q;
	logic [4:0] n_q, k_q;
	logic [MEM_AW-1:0] a_q;
	logic fwd_q;
	logic [31:0] fval_q;
	logic res_v_q, o_valid_q;
	result_t res_q, o_q;

	logic acc;
	pipe_t e;
	logic [31:0] ea;
	logic ebad;
	logic [TAG_W-1:0] sidx;
	logic scan_end;
	logic ram_we, ram_re;
	logic [MEM_AW-1:0] ram_waddr;
	logic [31:0] ram_wdata, ram_rdata;
	logic best_f;
	logic [SLOT_W-1:0] best;
	logic disp_ok;

	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign e = pipe_q[pi_q[PIPE_W-1:0]];
	assign ea = e.val1 + e.imm;
	assign ebad = (ea[31:MEM_AW] != '0);
	assign sidx = head_q + k_q[TAG_W-1:0];
	assign scan_end = (k_q >= n_q) || (sidx == pipe_q[pi_q[PIPE_W-1:0]].tag);

	always_comb begin
		best_f = 1'b0;
		best = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (busy_q[i] && !exec_q[i] && (!best_f || slot_q[i].seq < slot_q[best].seq)) begin
				best_f = 1'b1;
				best = SLOT_W'(i);
			end
		end
		disp_ok = best_f && slot_q[best].qj[4] && slot_q[best].qk[4] &&
			({4'd0, plen_q} < {4'd0, lat_q}) && (plen_q < (PIPE_W+1)'(MAX_LATENCY));
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = req.offset[MEM_AW-1:0];
		ram_wdata = req.base_value;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (acc && req.command == CMD_MEM_WRITE && req.offset[31:MEM_AW] == '0) begin
			ram_we = 1'b1;
		end
		ram_re = (state_q == ST_SCAN) && scan_end;
	end

	lsu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(a_q), .rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == MEM_AW'(MEM_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (acc && req.command == CMD_CYCLE) state_d = ST_PIPE;
			ST_PIPE: begin
				if (pi_q >= plen_q) begin
					state_d = ST_DISP;
				end else if (e.cycles == 4'd1 && !ebad && !e.store) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: if (scan_end) state_d = ST_MEM;
			ST_MEM: state_d = ST_PIPE;
			ST_DISP: state_d = ST_FIN;
			ST_FIN: if (!res_v_q || !o_valid_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			lat_q <= LATENCY_RESET;
			busy_q <= '0;
			exec_q <= '0;
			rv_q <= '0;
			plen_q <= '0;
			pi_q <= '0;
			keep_q <= '0;
			res_v_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) lat_q <= cfg_wdata;
			if (state_q == ST_FIN && res_v_q && (!o_valid_q || rsp.ready)) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (acc) begin
						unique case (req.command)
							CMD_ISSUE: begin
								if (!busy_q[req.rs_slot]) begin
									busy_q[req.rs_slot] <= 1'b1;
									exec_q[req.rs_slot] <= 1'b0;
									rv_q[req.dest_tag] <= 1'b0;
								end
							end
							CMD_RETIRE: rv_q[req.dest_tag] <= 1'b0;
							CMD_CYCLE: begin
								pi_q <= '0;
								keep_q <= '0;
								res_v_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_PIPE: begin
					if (pi_q >= plen_q) begin
						plen_q <= keep_q;
					end else if (e.cycles != 4'd1) begin
						keep_q <= keep_q + 1'b1;
						pi_q <= pi_q + 1'b1;
					end else if (ebad || e.store) begin
						rv_q[e.tag] <= e.store && !ebad;
						res_v_q <= 1'b1;
						busy_q[e.slot] <= 1'b0;
						exec_q[e.slot] <= 1'b0;
						pi_q <= pi_q + 1'b1;
					end
				end
				ST_MEM: begin
					rv_q[e.tag] <= 1'b0;
					res_v_q <= 1'b1;
					busy_q[e.slot] <= 1'b0;
					exec_q[e.slot] <= 1'b0;
					pi_q <= pi_q + 1'b1;
				end
				ST_DISP: begin
					if (disp_ok) begin
						exec_q[best] <= 1'b1;
						plen_q <= plen_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (req.command)
						CMD_ISSUE: begin
							if (!busy_q[req.rs_slot]) begin
								slot_q[req.rs_slot] <= '{store: req.is_store,
									vj: req.base_value, vk: req.store_data, imm: req.offset,
									seq: req.order_number, qj: req.base_wait_tag,
									qk: req.store_wait_tag, dest: req.dest_tag};
							end
						end
						CMD_BROADCAST: begin
							for (int i = 0; i < SLOTS; i++) begin
								if (busy_q[i] && slot_q[i].qj == {1'b0, req.dest_tag}) begin
									slot_q[i].vj <= req.base_value;
									slot_q[i].qj <= 5'h1F;
								end
								if (busy_q[i] && slot_q[i].qk == {1'b0, req.dest_tag}) begin
									slot_q[i].vk <= req.base_value;
									slot_q[i].qk <= 5'h1F;
								end
							end
						end
						CMD_CYCLE: begin
							head_q <= req.window_head;
							n_q <= (req.window_count > 5'(ROB_DEPTH)) ? 5'(ROB_DEPTH) :
								req.window_count;
						end
						default: ;
					endcase
				end
			end
			ST_PIPE: begin
				if (pi_q < plen_q) begin
					if (e.cycles != 4'd1) begin
						pipe_q[keep_q[PIPE_W-1:0]] <= '{store: e.store, val1: e.val1,
							val2: e.val2, imm: e.imm, tag: e.tag,
							cycles: e.cycles - 4'd1, slot: e.slot};
					end else if (ebad || e.store) begin
						raddr_q[e.tag] <= ea[9:0];
						rval_q[e.tag] <= e.val2;
						res_q <= '{done_tag: e.tag, bad_address: ebad, was_store: e.store,
							load_value: '0, store_address_out: ebad ? 10'd0 : ea[9:0],
							store_value_out: ebad ? 32'd0 : e.val2, was_forwarded: 1'b0};
					end else begin
						a_q <= ea[MEM_AW-1:0];
						k_q <= '0;
						fwd_q <= 1'b0;
					end
				end
			end
			ST_SCAN: begin
				if (!scan_end) begin
					if (rv_q[sidx] && raddr_q[sidx] == 10'(a_q)) begin
						fwd_q <= 1'b1;
						fval_q <= rval_q[sidx];
					end
					k_q <= k_q + 1'b1;
				end
			end
			ST_MEM: begin
				res_q <= '{done_tag: e.tag, bad_address: 1'b0, was_store: 1'b0,
					load_value: fwd_q ? fval_q : ram_rdata, store_address_out: '0,
					store_value_out: '0, was_forwarded: fwd_q};
			end
			ST_DISP: begin
				if (disp_ok) begin
					pipe_q[plen_q[PIPE_W-1:0]] <= '{store: slot_q[best].store,
						val1: slot_q[best].vj, val2: slot_q[best].vk, imm: slot_q[best].imm,
						tag: slot_q[best].dest, cycles: lat_q, slot: best};
				end
			end
			ST_FIN: if (res_v_q && (!o_valid_q || rsp.ready)) o_q <= res_q;
			default: ;
		endcase
	end

	assign rsp.valid = o_valid_q;
	assign rsp.done_tag = o_q.done_tag;
	assign rsp.bad_address = o_q.bad_address;
	assign rsp.was_store = o_q.was_store;
	assign rsp.load_value = o_q.load_value;
	assign rsp.store_address_out = o_q.store_address_out;
	assign rsp.store_value_out = o_q.store_value_out;
	assign rsp.was_forwarded = o_q.was_forwarded;
endmodule
`default_nettype wire

/* rtl/lsu_ram.sv */
`default_nettype none
module lsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/lsu_checker.sv */
`default_nettype none
`include "load_store_unit_macros.svh"
module lsu_checker
	import lsu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic [2:0] req_command,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [3:0] rsp_done_tag
);
	// A new result is only presented after the unit has been busy with a cycle command.
	`LSU_ASSERT_IMPL(a_rise_busy, clk, arst_n, $rose(rsp_valid), !$past(req_ready))
	`LSU_ASSERT_NEXT(a_cycle_busy, clk, arst_n,
		req_valid && req_ready && req_command == CMD_CYCLE, !req_ready)
	`LSU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_done_tag))
endmodule

bind load_store_unit lsu_checker u_lsu_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.req_command(req.command), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_done_tag(rsp.done_tag)
);
`default_nettype wire

/* tb/sv/lsu_tb_if.sv */
`timescale 1ns / 100ps
`default_nettype none
interface lsu_cfg_if;
	logic we;
	logic [3:0] wdata;
	modport source (output we, wdata);
	modport sink (input we, wdata);
endinterface
`default_nettype wire

/* tb/sv/lsu_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module lsu_scoreboard
	import lsu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic [2:0] command,
	input wire logic [1:0] rs_slot,
	input wire logic is_store,
	input wire logic [31:0] base_value,
	input wire logic [4:0] base_wait_tag,
	input wire logic [31:0] store_data,
	input wire logic [4:0] store_wait_tag,
	input wire logic [31:0] offset,
	input wire logic [3:0] dest_tag,
	input wire logic [31:0] order_number,
	input wire logic [3:0] window_head,
	input wire logic [4:0] window_count,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire result_t rsp_data,
	output int fail_count,
	output int pending
);
	typedef struct {
		bit busy, executing, store;
		bit [31:0] vj, vk, imm, seq;
		bit [4:0] qj, qk;
		bit [3:0] dest;
	} rs_entry_t;
	typedef struct {
		bit store;
		bit [31:0] val1, val2, imm;
		bit [3:0] tag, cycles;
		int slot;
	} stage_t;
	typedef struct {
		bit valid;
		bit [31:0] addr, value;
	} fwd_rec_t;

	bit [3:0] latency;
	rs_entry_t rs[SLOTS];
	stage_t pipe[$];
	fwd_rec_t fwd[ROB_DEPTH];
	bit [31:0] mem[MEM_WORDS];
	result_t completions[$];

	assign pending = completions.size();

	task automatic run_cycle(input bit [3:0] head, input bit [4:0] count);
		stage_t kept[$];
		stage_t e;
		result_t r;
		bit got, fwd_hit;
		bit [31:0] a, v;
		int n, idx, best;
		bit [32:0] oldest;
		got = 0;
		n = (count > ROB_DEPTH) ? ROB_DEPTH : count;
		foreach (pipe[i]) begin
			e = pipe[i];
			if (e.cycles == 1) begin
				a = e.val1 + e.imm;
				r = '0;
				r.done_tag = e.tag;
				r.was_store = e.store;
				if (a >= MEM_WORDS) begin
					r.bad_address = 1;
					fwd[e.tag].valid = 0;
				end else if (!e.store) begin
					fwd_hit = 0;
					v = 0;
					for (int k = 0; k < n; k++) begin
						idx = (head + k) % ROB_DEPTH;
						if (idx == e.tag) break;
						if (fwd[idx].valid && fwd[idx].addr == a) begin
							fwd_hit = 1;
							v = fwd[idx].value;
						end
					end
					r.load_value = fwd_hit ? v : mem[a];
					r.was_forwarded = fwd_hit;
					fwd[e.tag].valid = 0;
				end else begin
					fwd[e.tag] = '{1, a, e.val2};
					r.store_address_out = a[9:0];
					r.store_value_out = e.val2;
				end
				got = 1;
			end
			if (e.cycles > 0) e.cycles--;
			if (e.cycles == 0) begin
				rs[e.slot].busy = 0;
				rs[e.slot].executing = 0;
			end else begin
				kept = {kept, e};
			end
		end
		pipe = kept;
		if (got) completions = {completions, r};
		best = -1;
		oldest = 33'h1_0000_0000;
		for (int s = 0; s < SLOTS; s++)
			if (rs[s].busy && !rs[s].executing && rs[s].seq < oldest) begin
				oldest = rs[s].seq;
				best = s;
			end
		if (best >= 0 && rs[best].qj[4] && rs[best].qk[4] && pipe.size() < latency
				&& pipe.size() < MAX_LATENCY) begin
			rs[best].executing = 1;
			e.store = rs[best].store;
			e.val1 = rs[best].vj;
			e.val2 = rs[best].vk;
			e.imm = rs[best].imm;
			e.tag = rs[best].dest;
			e.cycles = latency;
			e.slot = best;
			pipe = {pipe, e};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			latency <= LATENCY_RESET;
			fail_count <= 0;
			foreach (rs[i]) rs[i] = '{default: 0};
			foreach (fwd[i]) fwd[i] = '{default: 0};
			foreach (mem[i]) mem[i] = 0;
			pipe.delete();
			completions.delete();
		end else begin
			if (cfg_we) latency <= cfg_wdata;
			if (rsp_valid && rsp_ready) begin
				if (completions.size() == 0) begin
					$error("result with nothing expected: tag %0d", rsp_data.done_tag);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = completions.pop_front();
					if (exp_r !== rsp_data) begin
						fail_count <= fail_count + 1;
						if (exp_r.done_tag !== rsp_data.done_tag)
							$error("done_tag: expected %h, got %h", exp_r.done_tag,
								rsp_data.done_tag);
						if (exp_r.bad_address !== rsp_data.bad_address)
							$error("bad_address: expected %h, got %h", exp_r.bad_address,
								rsp_data.bad_address);
						if (exp_r.was_store !== rsp_data.was_store)
							$error("was_store: expected %h, got %h", exp_r.was_store,
								rsp_data.was_store);
						if (exp_r.load_value !== rsp_data.load_value)
							$error("load_value: expected %h, got %h", exp_r.load_value,
								rsp_data.load_value);
						if (exp_r.store_address_out !== rsp_data.store_address_out)
							$error("store_address_out: expected %h, got %h",
								exp_r.store_address_out, rsp_data.store_address_out);
						if (exp_r.store_value_out !== rsp_data.store_value_out)
							$error("store_value_out: expected %h, got %h",
								exp_r.store_value_out, rsp_data.store_value_out);
						if (exp_r.was_forwarded !== rsp_data.was_forwarded)
							$error("was_forwarded: expected %h, got %h",
								exp_r.was_forwarded, rsp_data.was_forwarded);
					end
				end
			end
			if (req_valid && req_ready) begin
				case (command)
				CMD_ISSUE: begin
					if (!rs[rs_slot].busy) begin
						rs[rs_slot] = '{1, 0, is_store, base_value, store_data, offset,
							order_number, base_wait_tag, store_wait_tag, dest_tag};
						fwd[dest_tag].valid = 0;
					end
				end
				CMD_BROADCAST: begin
					foreach (rs[i]) begin
						if (!rs[i].busy) continue;
						if (rs[i].qj == {1'b0, dest_tag}) begin
							rs[i].vj = base_value;
							rs[i].qj = 5'h1f;
						end
						if (rs[i].qk == {1'b0, dest_tag}) begin
							rs[i].vk = base_value;
							rs[i].qk = 5'h1f;
						end
					end
				end
				CMD_CYCLE: run_cycle(window_head, window_count);
				CMD_MEM_WRITE: if (offset < MEM_WORDS) mem[offset] = base_value;
				CMD_RETIRE: fwd[dest_tag].valid = 0;
				default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* tb/sv/tb_load_store_unit.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_load_store_unit;
	import lsu_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic quiet = 0;
	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit [31:0] ticket = 0;

	lsu_in_if req();
	lsu_out_if rsp();
	lsu_cfg_if cfg();
	result_t rsp_data;

	assign rsp_data = '{rsp.done_tag, rsp.bad_address, rsp.was_store, rsp.load_value,
		rsp.store_address_out, rsp.store_value_out, rsp.was_forwarded};

	always #4 clk = ~clk;

	load_store_unit dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg.we), .cfg_wdata(cfg.wdata));

	lsu_scoreboard checker_i (.clk(clk), .arst_n(arst_n), .cfg_we(cfg.we),
		.cfg_wdata(cfg.wdata),
		.req_valid(req.valid), .req_ready(req.ready), .command(req.command),
		.rs_slot(req.rs_slot), .is_store(req.is_store), .base_value(req.base_value),
		.base_wait_tag(req.base_wait_tag), .store_data(req.store_data),
		.store_wait_tag(req.store_wait_tag), .offset(req.offset), .dest_tag(req.dest_tag),
		.order_number(req.order_number), .window_head(req.window_head),
		.window_count(req.window_count), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_data(rsp_data), .fail_count(fail_count), .pending(pending));

	initial begin
		cfg.we = 0;
		cfg.wdata = '0;
		req.valid = 0;
		req.command = CMD_CYCLE;
		req.rs_slot = 0;
		req.is_store = 0;
		req.base_value = 0;
		req.base_wait_tag = -1;
		req.store_data = 0;
		req.store_wait_tag = -1;
		req.offset = 0;
		req.dest_tag = 0;
		req.order_number = 0;
		req.window_head = 0;
		req.window_count = 0;
		rsp.ready = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) rsp.ready <= 0;
		else if (quiet) rsp.ready <= 1;
		else rsp.ready <= ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(input cmd_t cmd, input bit [1:0] slot, input bit st,
			input bit [31:0] bv, input bit [4:0] bq, input bit [31:0] sd,
			input bit [4:0] sq, input bit [31:0] off, input bit [3:0] tag,
			input bit [3:0] head, input bit [4:0] cnt);
		while (!quiet && $urandom_range(99) < 20) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.command <= cmd;
		req.rs_slot <= slot;
		req.is_store <= st;
		req.base_value <= bv;
		req.base_wait_tag <= bq;
		req.store_data <= sd;
		req.store_wait_tag <= sq;
		req.offset <= off;
		req.dest_tag <= tag;
		req.order_number <= ticket;
		req.window_head <= head;
		req.window_count <= cnt;
		ticket = ticket + 1 + $urandom_range(3);
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_latency(input bit [3:0] lat);
		drain();
		cfg.we <= 1;
		cfg.wdata <= lat;
		@(posedge clk);
		cfg.we <= 0;
		@(posedge clk);
	endtask

	task automatic pump(input int cnt, input bit [3:0] head);
		repeat (cnt) send(CMD_CYCLE, 0, 0, 0, 5'h1f, 0, 5'h1f, 0, 0, head, 5'd16);
	endtask

	task automatic random_item(input bit noisy);
		bit [31:0] off;
		bit [4:0] bq, sq;
		int pick;
		pick = $urandom_range(99);
		off = noisy ? $urandom : $urandom_range(15);
		bq = ($urandom_range(3) == 0) ? 5'($urandom_range(15)) : 5'h10 | 5'($urandom);
		sq = ($urandom_range(3) == 0) ? 5'($urandom_range(15)) : 5'h10 | 5'($urandom);
		if (pick < 30)
			send(CMD_ISSUE, 2'($urandom), 1'($urandom), noisy ? $urandom : $urandom_range(7),
				bq, $urandom, sq, off, 4'($urandom), 0, 0);
		else if (pick < 40)
			send(CMD_BROADCAST, 0, 0, noisy ? $urandom : $urandom_range(7), 0, 0, 0,
				0, 4'($urandom), 0, 0);
		else if (pick < 85)
			send(CMD_CYCLE, 0, 0, 0, 0, 0, 0, 0, 0, 4'($urandom), 5'($urandom_range(20)));
		else if (pick < 90)
			send(CMD_MEM_WRITE, 0, 0, $urandom, 0, 0, 0,
				noisy ? $urandom : $urandom_range(20), 0, 0, 0);
		else if (pick < 96)
			send(CMD_RETIRE, 0, 0, 0, 0, 0, 0, 0, 4'($urandom), 0, 0);
		else
			send(cmd_t'(3'($urandom_range(5, 7))), 2'($urandom), 1'($urandom), $urandom,
				5'($urandom), $urandom, 5'($urandom), $urandom, 4'($urandom),
				4'($urandom), 5'($urandom));
	endtask

	initial begin
		bit [3:0] lat;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(CMD_MEM_WRITE, 0, 0, 32'h7fffffff, 0, 0, 0, 3, 0, 0, 0);
		send(CMD_MEM_WRITE, 0, 0, 32'h80000000, 0, 0, 0, 1023, 0, 0, 0);
		send(CMD_MEM_WRITE, 0, 0, 32'h1, 0, 0, 0, 1024, 0, 0, 0);
		send(CMD_ISSUE, 0, 1, 5, 5'h1f, 32'hdeadbeef, 5'h1f, 32'hfffffffe, 1, 0, 0);
		send(CMD_ISSUE, 1, 0, 0, 5'd7, 0, 5'h1f, 3, 2, 0, 0);
		send(CMD_ISSUE, 2, 1, 32'h7fffffff, 5'h1f, 9, 5'h1f, 1, 3, 0, 0);
		send(CMD_ISSUE, 3, 0, 1023, 5'h1f, 0, 5'd8, 0, 15, 0, 0);
		send(CMD_ISSUE, 3, 0, 0, 5'h1f, 0, 5'h1f, 0, 4, 0, 0);
		pump(4, 0);
		send(CMD_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 7, 0, 0);
		send(CMD_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 8, 0, 0);
		pump(8, 0);
		send(CMD_ISSUE, 0, 0, 3, 5'h1f, 0, 5'h1f, 0, 5, 0, 0);
		pump(6, 1);
		send(CMD_RETIRE, 0, 0, 0, 0, 0, 0, 0, 3, 0, 0);
		send(CMD_CYCLE, 0, 0, 0, 0, 0, 0, 0, 0, 15, 31);
		send(CMD_CYCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
			0: lat = 1;
			1: lat = 8;
			2: lat = 15;
			3: lat = 0;
			default: lat = 4'($urandom_range(1, 8));
			endcase
			set_latency(lat);
			if (lat == 0) begin
				for (int i = 0; i < 20; i++) random_item(1);
				set_latency(3);
				pump(20, 0);
				continue;
			end
			quiet = (phase == 5);
			for (int i = 0; i < 250; i++) begin
				random_item(phase >= 6 && $urandom_range(9) < 3);
				if (i == 120) drain();
			end
			pump(40, 0);
			quiet = 0;
		end
		send(CMD_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int t = 0; t < 16; t++) send(CMD_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 4'(t), 0, 0);
		pump(60, 0);

		drain();
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/lsu_pkg.sv
rtl/lsu_if.sv
rtl/lsu_ram.sv
rtl/load_store_unit.sv
rtl/lsu_checker.sv
tb/sv/lsu_tb_if.sv
tb/sv/lsu_checker.sv
tb/sv/tb_load_store_unit.sv
